// File: sv/median_5x5_pixel_filter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 5x5 median pixel filter
// Checks compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_5X5_PIXEL_FILTER_ASSERT_SVH
`define MEDIAN_5X5_PIXEL_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Condition holds at every clock edge out of reset
`define MF5_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("mf5 invariant violated");
// Consequence holds in the cycle after the antecedent
`define MF5_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mf5 sequence violated");
`else
`define MF5_ASSERT_ALWAYS(lbl, cond)
`define MF5_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: sv/mf5_pkg.sv
// ----------------------------------------------------------------------------
// mf5_pkg
// Shared constants, types and size helpers of the 5x5 median pixel filter.
// ----------------------------------------------------------------------------
package mf5_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_SIZE   = 10;
    localparam int WIN        = 5;
    localparam int NW         = WIN * WIN;
    localparam int MID_RANK   = 12;
    localparam int EDGE       = 2;
    localparam int LINES      = 4;
    localparam int CENTER     = EDGE * WIN + EDGE;
    localparam int Q_DEPTH    = 4;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int DRN_W = WID_W + 1;
    localparam int QP_W  = $clog2(Q_DEPTH);
    localparam int QC_W  = $clog2(Q_DEPTH + 1);
    localparam int ADDR_W = 4;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    localparam logic [1:0] PLANE_LUMA = 2'd0;
    localparam logic [1:0] PLANE_NONE = 2'd3;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LUMA_EN      = 2'd2;
    localparam logic [1:0] REG_CHROMA_EN    = 2'd3;

    typedef struct packed {
        logic [11:0] frame_width;
        logic [12:0] frame_height;
        logic        luma_en;
        logic        chroma_en;
    } t_cfg;

    // Item classified by the front, before the line data returns
    typedef struct packed {
        logic       is_drain;
        logic       emit;
        logic       three;
        logic       med;
        logic       done;
        logic [1:0] plane;
        logic [7:0] pixel;
        logic [1:0] rot;
    } t_s1;

    // Queue entry: classified item with its new window column
    typedef struct packed {
        logic                  is_drain;
        logic                  emit;
        logic                  three;
        logic                  med;
        logic                  done;
        logic [1:0]            plane;
        logic [7:0]            pixel;
        logic [LINES-1:0][7:0] col;
    } t_entry;

    typedef struct packed {
        logic [QC_W-1:0] count;
        logic            full;
        logic            empty;
    } t_qstat;

    typedef struct packed {
        logic       drain;
        logic       emit;
        logic       three;
        logic       med;
        logic       done;
        logic [1:0] plane;
        logic [7:0] value;
    } t_meta;

    typedef logic [NW-1:0][7:0] t_win;

    // Clamped plane width; chroma is half of luma
    function automatic logic [WID_W-1:0] plane_width(input logic [11:0] fw,
                                                      input logic [1:0] plane);
        int unsigned v;
        v = fw;
        if (v < MIN_SIZE) v = MIN_SIZE;
        if (v > MAX_WIDTH) v = MAX_WIDTH;
        if (plane != PLANE_LUMA) v = v >> 1;
        return WID_W'(v);
    endfunction

    // Clamped plane height; chroma is half of luma
    function automatic logic [HGT_W-1:0] plane_height(input logic [12:0] fh,
                                                       input logic [1:0] plane);
        int unsigned v;
        v = fh;
        if (v < MIN_SIZE) v = MIN_SIZE;
        if (v > MAX_HEIGHT) v = MAX_HEIGHT;
        if (plane != PLANE_LUMA) v = v >> 1;
        return HGT_W'(v);
    endfunction

endpackage

// File: sv/mf5_if.sv
// ----------------------------------------------------------------------------
// mf5 stream interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mf5_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] pixel_in;
    logic [1:0] plane_sel;

    modport source (output valid, mode, pixel_in, plane_sel, input ready);
    modport sink   (input valid, mode, pixel_in, plane_sel, output ready);
endinterface

interface mf5_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;
    logic [1:0] plane_out;
    logic       plane_done;
    logic       run_last;

    modport source (output valid, pixel_out, plane_out, plane_done, run_last,
                    input ready);
    modport sink   (input valid, pixel_out, plane_out, plane_done, run_last,
                    output ready);
endinterface

// File: sv/median_5x5_pixel_filter.sv
// An item passes the line-buffer read register, the queue, ranking stages A
// and B and the output register; further results of the same item follow
// one a cycle while the output is ready. Throughput: one item per cycle while
// the queue has room; the last pixel of a row holds the single result register
// for its three results. Reset: synchronous, clears counters, queue pointers
// and valid flags, sets config defaults; line buffers are not cleared, need none.
// ----------------------------------------------------------------------------
// median_5x5_pixel_filter
// 5x5 median filter over raster-order 8-bit planes with APB configuration.
// ----------------------------------------------------------------------------
`include "median_5x5_pixel_filter_assert.svh"

module median_5x5_pixel_filter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mf5_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    mf5_in_if.sink                     i_pix,
    mf5_out_if.source                  o_res
);
    import mf5_pkg::*;

    t_cfg   r_cfg;
    t_qstat w_q_stat;
    t_entry w_push_entry, w_head;
    logic   w_push, w_pop, w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= 12'd720;
            r_cfg.frame_height <= 13'd576;
            r_cfg.luma_en      <= 1'b1;
            r_cfg.chroma_en    <= 1'b1;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_FRAME_WIDTH:  r_cfg.frame_width  <= pwdata[11:0];
                REG_FRAME_HEIGHT: r_cfg.frame_height <= pwdata[12:0];
                REG_LUMA_EN:      r_cfg.luma_en      <= pwdata[0];
                REG_CHROMA_EN:    r_cfg.chroma_en    <= pwdata[0];
                default:          r_cfg.luma_en      <= r_cfg.luma_en;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        case (paddr[3:2])
            REG_FRAME_WIDTH:  prdata = 32'(r_cfg.frame_width);
            REG_FRAME_HEIGHT: prdata = 32'(r_cfg.frame_height);
            REG_LUMA_EN:      prdata = 32'(r_cfg.luma_en);
            REG_CHROMA_EN:    prdata = 32'(r_cfg.chroma_en);
            default:          prdata = '0;
        endcase
    end

    mf5_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_pix    (i_pix),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    mf5_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    mf5_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_res    (o_res)
    );

    `MF5_ASSERT_ALWAYS(a_q_bound, w_q_stat.count <= QC_W'(Q_DEPTH))
    `MF5_ASSERT_ALWAYS(a_push_room, !(w_push && w_q_stat.full))
    `MF5_ASSERT_ALWAYS(a_done_last, !(o_res.valid && o_res.plane_done) || o_res.run_last)
    `MF5_ASSERT_NEXT(a_cfg_luma, w_cfg_wr && paddr[3:2] == REG_LUMA_EN, r_cfg.luma_en == $past(pwdata[0]))
endmodule

// File: sv/mf5_ram.sv
// ----------------------------------------------------------------------------
// mf5_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mf5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read; a read at the written address returns the old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/mf5_front.sv
// ----------------------------------------------------------------------------
// mf5_front
// Accepts items, tracks row, column, drain and plane, runs the line buffers
// and pushes classified items with their window column into the queue.
// ----------------------------------------------------------------------------
module mf5_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mf5_pkg::t_cfg   i_cfg,
    mf5_in_if.sink          i_pix,
    input  mf5_pkg::t_qstat i_q_stat,
    output logic            o_push,
    output mf5_pkg::t_entry o_entry
);
    import mf5_pkg::*;

    logic [HGT_W-1:0] r_row, n_row;
    logic [WID_W-1:0] r_col, n_col;
    logic [DRN_W-1:0] r_dcnt, n_dcnt;
    logic [1:0]       r_plane, n_plane;
    logic             r_s1_valid;
    t_s1              r_s1, n_s1;

    logic                  w_acc;
    logic                  w_item;
    logic [COL_W-1:0]      w_raddr;
    logic [LINES-1:0]      w_we;
    logic [LINES-1:0][7:0] w_rdata;

    logic [WID_W-1:0] w0, w1, col1, c, c_inc;
    logic [HGT_W-1:0] h0, row1, r;
    logic [DRN_W-1:0] w2x, dcol;
    logic             hi, restart, en;

    // Take an item while the queue has room for it and the one in flight
    assign i_pix.ready = ((QC_W+1)'(i_q_stat.count) + (QC_W+1)'(r_s1_valid))
                         < (QC_W+1)'(Q_DEPTH);
    assign w_acc = i_pix.valid && i_pix.ready;

    // Classify the item and work out the next counters
    always_comb begin
        w0   = plane_width(i_cfg.frame_width, r_plane);
        h0   = plane_height(i_cfg.frame_height, r_plane);
        row1 = r_row;
        col1 = r_col;
        if (col1 >= w0) begin
            col1 = '0;
            row1 = row1 + 1'b1;
        end
        n_row   = row1;
        n_col   = col1;
        n_dcnt  = r_dcnt;
        n_plane = r_plane;
        n_s1    = '0;
        w_item  = 1'b0;
        w_we    = '0;
        w_raddr = '0;
        w2x     = {w0, 1'b0};
        hi      = r_dcnt >= DRN_W'(w0);
        dcol    = hi ? (r_dcnt - DRN_W'(w0)) : r_dcnt;
        w1      = w0;
        r       = row1;
        c       = col1;
        c_inc   = '0;
        restart = 1'b0;
        en      = 1'b0;
        if (i_pix.mode == MODE_DRAIN) begin
            // Drain one stored pixel of the last two rows
            w_raddr = dcol[COL_W-1:0];
            if (row1 >= h0 && r_dcnt < w2x) begin
                w_item       = 1'b1;
                n_s1.is_drain = 1'b1;
                n_s1.emit    = 1'b1;
                n_s1.done    = (r_dcnt == w2x - 1'b1);
                n_s1.plane   = r_plane;
                n_s1.rot     = 2'(h0 - HGT_W'(EDGE) + HGT_W'(hi));
                n_dcnt       = r_dcnt + 1'b1;
            end
        end else if (i_pix.plane_sel != PLANE_NONE) begin
            // New plane, or a pixel past the last row, starts over
            restart = (i_pix.plane_sel != r_plane) || (row1 >= h0);
            if (restart) begin
                w1     = plane_width(i_cfg.frame_width, i_pix.plane_sel);
                r      = '0;
                c      = '0;
                n_dcnt = '0;
            end
            n_plane    = i_pix.plane_sel;
            en         = (i_pix.plane_sel == PLANE_LUMA) ? i_cfg.luma_en
                                                         : i_cfg.chroma_en;
            w_item     = 1'b1;
            n_s1.emit  = (r >= HGT_W'(EDGE)) && (c >= WID_W'(EDGE));
            n_s1.three = n_s1.emit && (c == w1 - 1'b1);
            n_s1.med   = en && (r >= HGT_W'(2*EDGE)) && (c >= WID_W'(2*EDGE));
            n_s1.plane = i_pix.plane_sel;
            n_s1.pixel = i_pix.pixel_in;
            n_s1.rot   = r[1:0];
            c_inc      = c + 1'b1;
            if (c_inc >= w1) begin
                n_col = '0;
                n_row = r + 1'b1;
            end else begin
                n_col = c_inc;
                n_row = r;
            end
            w_we[r[1:0]] = 1'b1;
            w_raddr      = c[COL_W-1:0];
        end
    end

    // Update counters on every transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_dcnt     <= '0;
            r_plane    <= PLANE_LUMA;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_acc && w_item;
            if (w_acc) begin
                r_row   <= n_row;
                r_col   <= n_col;
                r_dcnt  <= n_dcnt;
                r_plane <= n_plane;
            end
        end
    end

    // Hold the classified item while the line data is read
    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    // Four line buffers, one per stored row
    for (genvar g = 0; g < LINES; g++) begin : g_line
        mf5_ram #(
            .WIDTH (8),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (w_acc && w_we[g]),
            .i_waddr (w_raddr),
            .i_wdata (i_pix.pixel_in),
            .i_raddr (w_raddr),
            .o_rdata (w_rdata[g])
        );
    end

    // Rotate line data into window row order, oldest row first
    always_comb begin
        o_entry.is_drain = r_s1.is_drain;
        o_entry.emit     = r_s1.emit;
        o_entry.three    = r_s1.three;
        o_entry.med      = r_s1.med;
        o_entry.done     = r_s1.done;
        o_entry.plane    = r_s1.plane;
        o_entry.pixel    = r_s1.is_drain ? w_rdata[r_s1.rot] : r_s1.pixel;
        for (int k = 0; k < LINES; k++) begin
            o_entry.col[k] = w_rdata[2'(r_s1.rot + 2'(k))];
        end
    end

    assign o_push = r_s1_valid;
endmodule

// File: sv/mf5_fifo.sv
// ----------------------------------------------------------------------------
// mf5_fifo
// Short queue that decouples item classification from filtering.
// ----------------------------------------------------------------------------
module mf5_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mf5_pkg::t_entry i_entry,
    input  logic            i_pop,
    output mf5_pkg::t_entry o_head,
    output mf5_pkg::t_qstat o_stat
);
    import mf5_pkg::*;

    t_entry          r_mem [Q_DEPTH];
    logic [QP_W-1:0] r_wp, r_rp;
    logic [QC_W-1:0] r_cnt;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QP_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QP_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    assign o_head       = r_mem[r_rp];
    assign o_stat.count = r_cnt;
    assign o_stat.full  = (r_cnt == QC_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
endmodule

// File: sv/mf5_back.sv
// ----------------------------------------------------------------------------
// mf5_back
// Shifts the 5x5 window, ranks its 25 samples in two registered steps and
// sends up to three results per item through an output register.
// ----------------------------------------------------------------------------
module mf5_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mf5_pkg::t_qstat i_q_stat,
    input  mf5_pkg::t_entry i_head,
    output logic            o_pop,
    mf5_out_if.source       o_res
);
    import mf5_pkg::*;

    t_win  r_win, n_win;
    logic  r_a_valid, r_b_valid;
    t_meta r_a, r_b, n_meta;
    t_win  r_a_win, r_b_win;
    logic [NW-1:0][NW-1:0] r_a_lt, n_lt;
    logic [NW-1:0]         r_b_sel, n_sel;

    logic            r_e_valid;
    logic [2:0][7:0] r_e_vals;
    logic [1:0]      r_e_idx, r_e_last;
    logic [1:0]      r_e_plane;
    logic            r_e_done;

    logic       w_adv, w_out_xfer;
    logic [7:0] w_med;

    assign w_out_xfer = o_res.valid && o_res.ready;
    // Pipeline moves when the output register is free or frees up now
    assign w_adv = !r_e_valid || (w_out_xfer && (r_e_idx == r_e_last));
    assign o_pop = w_adv && !i_q_stat.empty;

    // Shift the window left and bring in the new column
    always_comb begin
        for (int k = 0; k < WIN; k++) begin
            for (int j = 0; j < WIN - 1; j++) begin
                n_win[k*WIN + j] = r_win[k*WIN + j + 1];
            end
        end
        for (int k = 0; k < LINES; k++) begin
            n_win[k*WIN + WIN - 1] = i_head.col[k];
        end
        n_win[NW-1] = i_head.pixel;
    end

    // Pairwise order: sample j precedes sample i, ties broken by position
    always_comb begin
        for (int i = 0; i < NW; i++) begin
            for (int j = 0; j < NW; j++) begin
                n_lt[i][j] = (n_win[j] < n_win[i]) ||
                             ((n_win[j] == n_win[i]) && (j < i));
            end
        end
    end

    // Mark the sample of middle rank
    always_comb begin
        for (int i = 0; i < NW; i++) begin
            n_sel[i] = ($countones(r_a_lt[i]) == MID_RANK);
        end
    end

    // Pick the marked sample
    always_comb begin
        w_med = '0;
        for (int i = 0; i < NW; i++) begin
            w_med = w_med | (r_b_win[i] & {8{r_b_sel[i]}});
        end
    end

    always_comb begin
        n_meta.drain = i_head.is_drain;
        n_meta.emit  = i_head.emit;
        n_meta.three = i_head.three;
        n_meta.med   = i_head.med;
        n_meta.done  = i_head.done;
        n_meta.plane = i_head.plane;
        n_meta.value = i_head.pixel;
    end

    // Control of the stages and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_e_idx   <= '0;
        end else begin
            if (w_adv) begin
                r_a_valid <= o_pop;
                r_b_valid <= r_a_valid;
            end
            if (w_adv && r_b_valid && r_b.emit) begin
                r_e_valid <= 1'b1;
                r_e_idx   <= '0;
            end else if (w_out_xfer) begin
                if (r_e_idx == r_e_last) begin
                    r_e_valid <= 1'b0;
                end else begin
                    r_e_idx <= r_e_idx + 1'b1;
                end
            end
        end
    end

    // Payload of the window, the stages and the output register
    always_ff @(posedge i_clk) begin
        if (o_pop && !i_head.is_drain) begin
            r_win <= n_win;
        end
        if (w_adv) begin
            r_a     <= n_meta;
            r_a_win <= n_win;
            r_a_lt  <= n_lt;
            r_b     <= r_a;
            r_b_win <= r_a_win;
            r_b_sel <= n_sel;
        end
        if (w_adv && r_b_valid && r_b.emit) begin
            r_e_vals[0] <= r_b.drain ? r_b.value
                                     : (r_b.med ? w_med : r_b_win[CENTER]);
            r_e_vals[1] <= r_b_win[CENTER + 1];
            r_e_vals[2] <= r_b_win[CENTER + 2];
            r_e_last    <= r_b.three ? 2'd2 : 2'd0;
            r_e_plane   <= r_b.plane;
            r_e_done    <= r_b.done;
        end
    end

    // Drive the result channel
    always_comb begin
        case (r_e_idx)
            2'd1:    o_res.pixel_out = r_e_vals[1];
            2'd2:    o_res.pixel_out = r_e_vals[2];
            default: o_res.pixel_out = r_e_vals[0];
        endcase
    end

    assign o_res.valid      = r_e_valid;
    assign o_res.plane_out  = r_e_plane;
    assign o_res.plane_done = r_e_done;
    assign o_res.run_last   = (r_e_idx == r_e_last);
endmodule
